// ----- hdl/dbscan_pkg.sv -----
// ----------------------------------------------------------------------------
// DBSCAN clustering package
// Shared payload types, controller/datapath command and status bundles, and
// the fixed field widths and register codes of the clustering block.
// ----------------------------------------------------------------------------
package dbscan_pkg;

    localparam int COORD_W   = 16;
    localparam int POINT_W   = 3 * COORD_W;
    localparam int LABEL_W   = 7;
    localparam int IDX_OUT_W = 6;
    localparam int RAD_W     = 34;
    localparam int MINN_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = RAD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NEIGH = 2'd1;

    localparam logic [RAD_W-1:0]  RADIUS_RESET = 34'd4194304;
    localparam logic [MINN_W-1:0] MIN_RESET    = 7'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      set_end;
    } t_in_item;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] point_index;
        logic [LABEL_W-1:0]   cluster_id;
        logic                 final_label;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic next_i;
        logic pick;
        logic fetch_p;
        logic latch;
        logic step;
        logic new_cluster;
        logic enq_start;
        logic enq_step;
        logic pop;
        logic relabel;
        logic qtake;
        logic out_read;
        logic next_k;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic i_end;
        logic i_vis;
        logic j_end;
        logic pipe_busy;
        logic core;
        logic q_avail;
        logic q_vis;
        logic k_last;
    } t_sts;

endpackage

// ----- hdl/dbscan_dp.sv -----
// ----------------------------------------------------------------------------
// DBSCAN datapath
// Point store, neighbour distance pipeline, marks, label store, seed queue
// and configuration registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
module dbscan_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dbscan_pkg::t_cmd                    i_cmd,
    output dbscan_pkg::t_sts                    o_sts,
    input  dbscan_pkg::t_in_item                i_item,
    input  logic                                i_cfg_we,
    input  logic [dbscan_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dbscan_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output dbscan_pkg::t_out_item               o_item
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [dbscan_pkg::POINT_W-1:0] r_mem [MAX_POINTS];
    logic [dbscan_pkg::POINT_W-1:0] r_rd;
    logic [dbscan_pkg::LABEL_W-1:0] r_lab [MAX_POINTS];
    logic [dbscan_pkg::LABEL_W-1:0] r_lab_rd;
    logic [IW-1:0]                  r_qmem [MAX_POINTS];
    logic [IW-1:0]                  r_q_rd;

    logic signed [dbscan_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [CW-1:0] r_loaded, r_i, r_j, r_k, r_head, r_tail, r_cnt;
    logic [IW-1:0] r_p;
    logic [MAX_POINTS-1:0] r_vis, r_que, r_lvld, r_near;
    logic [dbscan_pkg::LABEL_W-1:0] r_cid;
    logic r_obit;
    logic [dbscan_pkg::RAD_W-1:0]  r_rad;
    logic [dbscan_pkg::MINN_W-1:0] r_min;

    logic r_v1, r_v2;
    logic [IW-1:0] r_j1, r_j2;
    logic [31:0] r_sqx, r_sqy, r_sqz;

    logic [IW-1:0] rd_addr;
    logic signed [dbscan_pkg::COORD_W:0] dx, dy, dz;
    logic [31:0] sqx, sqy, sqz;
    logic [dbscan_pkg::RAD_W-1:0] sq_sum;
    logic near_hit;
    logic lab_we;
    logic [IW-1:0] lab_addr;
    logic [dbscan_pkg::LABEL_W-1:0] lab_data;

    assign rd_addr = i_cmd.fetch_p ? r_p : r_j[IW-1:0];

    // Difference against the latched centre point, then squares.
    assign dx  = {r_rd[47], r_rd[47:32]} - {r_px[15], r_px};
    assign dy  = {r_rd[31], r_rd[31:16]} - {r_py[15], r_py};
    assign dz  = {r_rd[15], r_rd[15:0]}  - {r_pz[15], r_pz};
    assign sqx = 32'(dx * dx);
    assign sqy = 32'(dy * dy);
    assign sqz = 32'(dz * dz);
    assign sq_sum = 34'(r_sqx) + 34'(r_sqy) + 34'(r_sqz);
    assign near_hit = r_v2 && (r_j2 != r_p) && (sq_sum <= r_rad);

    assign lab_we   = i_cmd.new_cluster || i_cmd.qtake || (i_cmd.relabel && !r_lvld[r_q_rd]);
    assign lab_addr = i_cmd.new_cluster ? r_p : r_q_rd;
    assign lab_data = i_cmd.new_cluster ? r_cid + 7'd1 : r_cid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_loaded < CW'(MAX_POINTS)) begin
            r_mem[r_loaded[IW-1:0]] <= {i_item.coord_x, i_item.coord_y, i_item.coord_z};
        end
        r_rd <= r_mem[rd_addr];
        if (lab_we) begin
            r_lab[lab_addr] <= lab_data;
        end
        if (i_cmd.out_read) begin
            r_lab_rd <= r_lab[r_k[IW-1:0]];
        end
        if (i_cmd.enq_step && r_near[r_j[IW-1:0]] && !r_que[r_j[IW-1:0]]) begin
            r_qmem[r_tail[IW-1:0]] <= r_j[IW-1:0];
        end
        if (i_cmd.pop) begin
            r_q_rd <= r_qmem[r_head[IW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_px <= r_rd[47:32];
            r_py <= r_rd[31:16];
            r_pz <= r_rd[15:0];
        end
        r_j1  <= r_j[IW-1:0];
        r_j2  <= r_j1;
        r_sqx <= sqx;
        r_sqy <= sqy;
        r_sqz <= sqz;
        if (i_cmd.pick) begin
            r_p <= r_i[IW-1:0];
        end else if (i_cmd.qtake) begin
            r_p <= r_q_rd;
        end
        if (i_cmd.out_read) begin
            r_obit <= r_lvld[r_k[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad    <= dbscan_pkg::RADIUS_RESET;
            r_min    <= dbscan_pkg::MIN_RESET;
            r_loaded <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_vis    <= '0;
            r_que    <= '0;
            r_lvld   <= '0;
            r_near   <= '0;
            r_cid    <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == dbscan_pkg::CFG_RADIUS_SQ) begin
                    r_rad <= i_cfg_data;
                end else if (i_cfg_idx == dbscan_pkg::CFG_MIN_NEIGH) begin
                    r_min <= i_cfg_data[dbscan_pkg::MINN_W-1:0];
                end
            end
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
            if (i_cmd.load && r_loaded < CW'(MAX_POINTS)) begin
                r_loaded <= r_loaded + CW'(1);
            end
            if (i_cmd.next_i) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.pick) begin
                r_vis[r_i[IW-1:0]] <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_cnt  <= '0;
                r_near <= '0;
                r_j    <= '0;
            end
            if (i_cmd.step) begin
                r_j <= r_j + CW'(1);
            end
            if (near_hit) begin
                r_near[r_j2] <= 1'b1;
                r_cnt        <= r_cnt + CW'(1);
            end
            if (i_cmd.new_cluster) begin
                r_cid         <= r_cid + 7'd1;
                r_lvld[r_p]   <= 1'b1;
                r_que[r_p]    <= 1'b1;
                r_head        <= '0;
                r_tail        <= '0;
            end
            if (i_cmd.enq_start) begin
                r_j <= '0;
            end
            if (i_cmd.enq_step) begin
                r_j <= r_j + CW'(1);
                if (r_near[r_j[IW-1:0]] && !r_que[r_j[IW-1:0]]) begin
                    r_que[r_j[IW-1:0]] <= 1'b1;
                    r_tail             <= r_tail + CW'(1);
                end
            end
            if (i_cmd.pop) begin
                r_head <= r_head + CW'(1);
            end
            if (i_cmd.qtake) begin
                r_vis[r_q_rd]  <= 1'b1;
                r_lvld[r_q_rd] <= 1'b1;
            end
            if (i_cmd.relabel) begin
                r_lvld[r_q_rd] <= 1'b1;
            end
            if (i_cmd.next_k) begin
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.clear) begin
                r_loaded <= '0;
                r_i      <= '0;
                r_k      <= '0;
                r_head   <= '0;
                r_tail   <= '0;
                r_cid    <= '0;
                r_vis    <= '0;
                r_que    <= '0;
                r_lvld   <= '0;
            end
        end
    end

    assign o_sts.i_end     = (r_i == r_loaded);
    assign o_sts.i_vis     = r_vis[r_i[IW-1:0]];
    assign o_sts.j_end     = (r_j == r_loaded);
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.core      = 8'(r_cnt) >= {1'b0, r_min};
    assign o_sts.q_avail   = (r_head != r_tail);
    assign o_sts.q_vis     = r_vis[r_q_rd];
    assign o_sts.k_last    = (r_k == (r_loaded - CW'(1)));

    assign o_item.point_index = 6'(r_k);
    assign o_item.cluster_id  = r_obit ? r_lab_rd : '0;
    assign o_item.final_label = o_sts.k_last;

    a_loaded_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_head != r_tail)
        else $error("seed queue popped while empty");
    a_seed_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.new_cluster |=> r_que[$past(r_p)] && r_lvld[$past(r_p)])
        else $error("cluster seed not marked");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= r_loaded)
        else $error("seed queue holds more points than loaded");

endmodule

// ----- hdl/dbscan_ctrl.sv -----
// ----------------------------------------------------------------------------
// DBSCAN controller
// State machine that sequences loading, neighbour sweeps, breadth-first
// cluster growth and label output.
// ----------------------------------------------------------------------------
module dbscan_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_set_end,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dbscan_pkg::t_sts i_sts,
    output dbscan_pkg::t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_PICK   = 11'b00000000010,
        S_FETCH  = 11'b00000000100,
        S_LATCH  = 11'b00000001000,
        S_SWEEP  = 11'b00000010000,
        S_DECIDE = 11'b00000100000,
        S_ENQ    = 11'b00001000000,
        S_QNEXT  = 11'b00010000000,
        S_QCHK   = 11'b00100000000,
        S_ORD    = 11'b01000000000,
        S_SHOW   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_qmode, n_qmode;

    always_comb begin
        n_state     = r_state;
        n_qmode     = r_qmode;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_set_end) begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                if (i_sts.i_end) begin
                    n_state = S_ORD;
                end else if (i_sts.i_vis) begin
                    o_cmd.next_i = 1'b1;
                end else begin
                    o_cmd.pick = 1'b1;
                    n_qmode    = 1'b0;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch_p = 1'b1;
                n_state       = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.latch = 1'b1;
                n_state     = S_SWEEP;
            end
            S_SWEEP: begin
                if (!i_sts.j_end) begin
                    o_cmd.step = 1'b1;
                end else if (!i_sts.pipe_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.core) begin
                    o_cmd.new_cluster = !r_qmode;
                    o_cmd.enq_start   = 1'b1;
                    n_state           = S_ENQ;
                end else if (!r_qmode) begin
                    o_cmd.next_i = 1'b1;
                    n_state      = S_PICK;
                end else begin
                    n_state = S_QNEXT;
                end
            end
            S_ENQ: begin
                if (i_sts.j_end) begin
                    n_state = S_QNEXT;
                end else begin
                    o_cmd.enq_step = 1'b1;
                end
            end
            S_QNEXT: begin
                if (i_sts.q_avail) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_QCHK;
                end else begin
                    o_cmd.next_i = 1'b1;
                    n_state      = S_PICK;
                end
            end
            S_QCHK: begin
                if (i_sts.q_vis) begin
                    o_cmd.relabel = 1'b1;
                    n_state       = S_QNEXT;
                end else begin
                    o_cmd.qtake = 1'b1;
                    n_qmode     = 1'b1;
                    n_state     = S_FETCH;
                end
            end
            S_ORD: begin
                o_cmd.out_read = 1'b1;
                n_state        = S_SHOW;
            end
            S_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.k_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.next_k = 1'b1;
                        n_state      = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qmode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qmode <= n_qmode;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("label withdrawn before transfer");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output active together");

endmodule

// ----- hdl/dbscan_point_clustering.sv -----
// ----------------------------------------------------------------------------
// DBSCAN point clustering, top level
// Loads 3D points, clusters them by density and emits one label per point.
// ----------------------------------------------------------------------------
// Usage: points arrive on the input channel (valid/ready), one transfer per
// point, each in signed Q3.12. Up to MAX_POINTS points are stored; further
// points are dropped, but a dropped point carrying set_end still closes the
// set. The transfer with set_end high starts clustering, during which the
// input is not ready. Each unvisited point and each point taken from the
// seed queue gets one neighbour sweep over the point store (one read
// port), and each core point a further enqueue sweep. Labels then leave
// on the output channel in load order, each one read from the label store
// and then output, cluster_id 0 meaning noise and final_label marking the
// last one. A stalled receiver simply holds the current label; the block
// takes no new point until the last label has been transferred, after
// which the set, labels and marks are cleared. The configuration port
// writes the squared radius (index 0) or the minimum neighbour count
// (index 1); other indices are ignored. Reset (synchronous, active low)
// empties the set and restores the default radius and neighbour count.
// ----------------------------------------------------------------------------
module dbscan_point_clustering #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dbscan_pkg::t_in_item                i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dbscan_pkg::t_out_item               o_out_item,
    input  logic                                i_cfg_we,
    input  logic [dbscan_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dbscan_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dbscan_pkg::t_cmd cmd;
    dbscan_pkg::t_sts sts;

    // Sequencing of load, sweeps, queue growth and label output.
    dbscan_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_set_end   (i_in_item.set_end),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Storage, distance pipeline and configuration.
    dbscan_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_item     (o_out_item)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for dbscan_point_clustering
// Loads point sets through the input channel and predicts the labels that the
// block should return. Each label transfer is checked against the oldest
// prediction. Runs a directed part covering the corner cases, then random
// clustered and scattered sets under several register settings.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS       = 64;
    localparam int STALL_MAX  = 40000;  // cycles with no transfer before giving up
    localparam int HOLD_LEN   = 500;    // long receiver hold-off
    localparam int RAND_ITEMS = 460;

    // Register indices that the block does not decode.
    localparam logic [dbscan_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [dbscan_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    dbscan_pkg::t_in_item                i_in_item = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    dbscan_pkg::t_out_item               o_out_item;
    logic                                i_cfg_we = 1'b0;
    logic [dbscan_pkg::CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [dbscan_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    dbscan_point_clustering #(.MAX_POINTS(NPTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Points waiting to be offered, and labels the block still owes us.
    dbscan_pkg::t_in_item  point_fifo[$];
    dbscan_pkg::t_out_item label_fifo[$];

    int  send_idle_pct = 29;
    int  recv_idle_pct = 29;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;
    int  error_count   = 0;
    int  quiet_cycles  = 0;
    int  items_queued  = 0;

    // Shadow of the block's registers and the set being loaded.
    logic [dbscan_pkg::RAD_W-1:0]          shadow_radius_sq = dbscan_pkg::RADIUS_RESET;
    logic [dbscan_pkg::MINN_W-1:0]         shadow_min_neigh = dbscan_pkg::MIN_RESET;
    logic signed [dbscan_pkg::COORD_W-1:0] set_x[NPTS];
    logic signed [dbscan_pkg::COORD_W-1:0] set_y[NPTS];
    logic signed [dbscan_pkg::COORD_W-1:0] set_z[NPTS];
    int                                    set_count = 0;

    // Squared distance in 2^-24 units; fits in 34 bits for any pair.
    function automatic bit within_radius(int a, int b);
        longint dx, dy, dz;
        dx = longint'(set_x[a]) - longint'(set_x[b]);
        dy = longint'(set_y[a]) - longint'(set_y[b]);
        dz = longint'(set_z[a]) - longint'(set_z[b]);
        return (dx * dx + dy * dy + dz * dz) <= longint'({30'd0, shadow_radius_sq});
    endfunction

    function automatic int neighbour_count(int p, int n);
        int c;
        c = 0;
        for (int j = 0; j < n; j++) begin
            if (j != p && within_radius(p, j)) c++;
        end
        return c;
    endfunction

    // Breadth-first density clustering of the stored set; the resulting
    // labels are appended to the label FIFO in load order.
    function automatic void cluster_and_label(int n);
        logic [dbscan_pkg::LABEL_W-1:0] label[NPTS];
        bit                             visited[NPTS];
        bit                             queued[NPTS];
        int                             seeds[NPTS];
        int                             head, tail, q;
        logic [dbscan_pkg::LABEL_W-1:0] next_id, id;
        dbscan_pkg::t_out_item          lab;
        next_id = '0;
        for (int k = 0; k < NPTS; k++) begin
            label[k] = '0;
            visited[k] = 1'b0;
            queued[k] = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (visited[i]) continue;
            visited[i] = 1'b1;
            if (neighbour_count(i, n) < int'(shadow_min_neigh)) continue;
            next_id = next_id + 1'b1;
            id = next_id;
            label[i] = id;
            queued[i] = 1'b1;
            head = 0;
            tail = 0;
            for (int j = 0; j < n; j++) begin
                if (j != i && !queued[j] && within_radius(i, j) && tail < NPTS) begin
                    queued[j] = 1'b1;
                    seeds[tail++] = j;
                end
            end
            while (head < tail) begin
                q = seeds[head++];
                if (visited[q]) begin
                    if (label[q] == '0) label[q] = id;
                    continue;
                end
                visited[q] = 1'b1;
                label[q] = id;
                if (neighbour_count(q, n) >= int'(shadow_min_neigh)) begin
                    for (int j = 0; j < n; j++) begin
                        if (j != q && !queued[j] && within_radius(q, j) && tail < NPTS) begin
                            queued[j] = 1'b1;
                            seeds[tail++] = j;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            lab.point_index = i[dbscan_pkg::IDX_OUT_W-1:0];
            lab.cluster_id  = label[i];
            lab.final_label = (i == n - 1);
            label_fifo = {label_fifo, lab};
        end
    endfunction

    // Store an accepted point (if there is room) and close the set on set_end.
    function automatic void accept_point(dbscan_pkg::t_in_item pt);
        if (set_count < NPTS) begin
            set_x[set_count] = pt.coord_x;
            set_y[set_count] = pt.coord_y;
            set_z[set_count] = pt.coord_z;
            set_count++;
        end
        if (pt.set_end) begin
            cluster_and_label(set_count);
            set_count = 0;
        end
    endfunction

    // Sender: a new point is only presented once the previous one has been
    // transferred, so valid never drops while a point is pending.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (point_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item  <= point_fifo.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with random gaps and one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_request && o_out_valid) begin
            hold_request <= 1'b0;
            hold_left    <= HOLD_LEN;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each input transfer, check each label transfer.
    always @(posedge i_clk) begin
        dbscan_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) accept_point(i_in_item);
            if (o_out_valid && i_out_ready) begin
                if (label_fifo.size() == 0) begin
                    $display("%0t: unexpected label, expected none, actual %p",
                             $time, o_out_item);
                    error_count++;
                end else begin
                    want = label_fifo.pop_front();
                    if (o_out_item.point_index !== want.point_index) begin
                        $display("%0t: point_index expected %0d actual %0d", $time,
                                 want.point_index, o_out_item.point_index);
                        error_count++;
                    end
                    if (o_out_item.cluster_id !== want.cluster_id) begin
                        $display("%0t: cluster_id of point %0d expected %0d actual %0d",
                                 $time, want.point_index, want.cluster_id,
                                 o_out_item.cluster_id);
                        error_count++;
                    end
                    if (o_out_item.final_label !== want.final_label) begin
                        $display("%0t: final_label of point %0d expected %0d actual %0d",
                                 $time, want.point_index, want.final_label,
                                 o_out_item.final_label);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: clustering a full set runs with no transfer at all, so the
    // limit sits well above the length of clustering plus the hold-off.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_point(int x, int y, int z, bit last);
        dbscan_pkg::t_in_item pt;
        pt.coord_x = x[dbscan_pkg::COORD_W-1:0];
        pt.coord_y = y[dbscan_pkg::COORD_W-1:0];
        pt.coord_z = z[dbscan_pkg::COORD_W-1:0];
        pt.set_end = last;
        point_fifo = {point_fifo, pt};
        items_queued++;
    endtask

    // Wait until every point is transferred and every label returned, then
    // let the block clear its set.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (point_fifo.size() != 0 || i_in_valid || label_fifo.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dbscan_pkg::CFG_IDX_W-1:0] idx,
                             logic [dbscan_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == dbscan_pkg::CFG_RADIUS_SQ) begin
            shadow_radius_sq = value[dbscan_pkg::RAD_W-1:0];
        end else if (idx == dbscan_pkg::CFG_MIN_NEIGH) begin
            shadow_min_neigh = value[dbscan_pkg::MINN_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A set of n points scattered around a few centres, with a spread of
    // roughly the radius so that both neighbours and noise turn up.
    task automatic queue_set(int n, int spread);
        int cx[4], cy[4], cz[4];
        int c;
        for (int k = 0; k < 4; k++) begin
            cx[k] = $urandom_range(65535) - 32768;
            cy[k] = $urandom_range(65535) - 32768;
            cz[k] = $urandom_range(65535) - 32768;
        end
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(3);
            if ($urandom_range(9) == 0) begin
                queue_point($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), i == n - 1);
            end else begin
                queue_point(cx[c] + $urandom_range(2 * spread) - spread,
                            cy[c] + $urandom_range(2 * spread) - spread,
                            cz[c] + $urandom_range(2 * spread) - spread, i == n - 1);
            end
        end
    endtask

    initial begin
        int r, n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Default registers: a duplicate pair, a point exactly on the radius,
        // the coordinate extremes, and a set of a single point.
        queue_point(0, 0, 0, 0);
        queue_point(0, 0, 0, 0);
        queue_point(2048, 0, 0, 0);
        queue_point(0, -2048, 0, 0);
        queue_point(-32768, -32768, -32768, 0);
        queue_point(32767, 32767, 32767, 1);
        queue_point(-1, 1, -1, 1);
        wait_drained();

        // No neighbours needed and a zero radius: only coincident points join.
        write_reg(dbscan_pkg::CFG_MIN_NEIGH, 0);
        write_reg(dbscan_pkg::CFG_RADIUS_SQ, 0);
        queue_point(100, 100, 100, 0);
        queue_point(100, 100, 100, 0);
        queue_point(101, 100, 100, 1);
        wait_drained();

        // A neighbour count above the set size turns everything into noise.
        write_reg(dbscan_pkg::CFG_RADIUS_SQ, 34'h3_FFFF_FFFF);
        write_reg(dbscan_pkg::CFG_MIN_NEIGH, 64);
        write_reg(CFG_SPARE_A, 34'h1_2345_6789);
        for (int i = 0; i < 4; i++) queue_point(i * 9000, -i * 7000, i, i == 3);
        wait_drained();

        // Largest radius in range: opposite corners are still neighbours.
        write_reg(dbscan_pkg::CFG_RADIUS_SQ, 34'd12884508675);
        write_reg(dbscan_pkg::CFG_MIN_NEIGH, 1);
        write_reg(CFG_SPARE_B, '1);
        queue_point(-32768, -32768, -32768, 0);
        queue_point(32767, 32767, 32767, 0);
        queue_point(0, 0, 0, 1);
        wait_drained();

        // Overflow: a full set plus dropped points, the last one closing it,
        // sent with no idling and a long receiver hold-off while the next set
        // is already offered.
        write_reg(dbscan_pkg::CFG_RADIUS_SQ, 34'd4194304);
        write_reg(dbscan_pkg::CFG_MIN_NEIGH, 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        queue_set(67, 1500);
        queue_set(8, 1500);
        wait_drained();
        send_idle_pct = 29;
        recv_idle_pct = 29;

        while (items_queued < RAND_ITEMS) begin
            if ($urandom_range(3) == 0) begin
                write_reg(dbscan_pkg::CFG_RADIUS_SQ, {$urandom_range(3), $urandom});
                r = 2048;
            end else begin
                r = $urandom_range(1, 4096);
                write_reg(dbscan_pkg::CFG_RADIUS_SQ, r * r);
            end
            if ($urandom_range(7) == 0) begin
                write_reg(dbscan_pkg::CFG_MIN_NEIGH, $urandom_range(64));
            end else begin
                write_reg(dbscan_pkg::CFG_MIN_NEIGH, $urandom_range(4));
            end
            n = ($urandom_range(15) == 0) ? $urandom_range(40, 64) : $urandom_range(2, 12);
            queue_set(n, r);
            if ($urandom_range(2) == 0) queue_set($urandom_range(1, 10), r);
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (error_count == 0 && label_fifo.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
